@@ hw/rtl/kpc_pkg.sv @@
package kpc_pkg;

    // Press classifier states, encoded as they appear on o_press_state
    typedef enum logic [2:0] {
        ST_RESET    = 3'd0,
        ST_WAIT     = 3'd1,
        ST_PRESSED  = 3'd2,
        ST_BOUNCE   = 3'd3,
        ST_DEBOUNCE = 3'd4,
        ST_SHORT    = 3'd5,
        ST_LONG     = 3'd6,
        ST_RELEASE  = 3'd7
    } t_press_state;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_BOUNCE_MS = 1'b0,
        CFG_HOLD_MS   = 1'b1
    } t_cfg_index;

    localparam int unsigned CFG_W   = 16;
    localparam int unsigned TIME_W  = 32;

    localparam logic [CFG_W-1:0] BOUNCE_MS_RST = 16'd20;
    localparam logic [CFG_W-1:0] HOLD_MS_RST   = 16'd1000;

endpackage

@@ hw/rtl/key_press_classifier_core.sv @@
// Push-button press classifier. Each request is one poll of a button (level low
// while pressed) plus a free-running millisecond timestamp, and yields exactly
// one result: the state after the poll and one-poll short/long press flags.
// A press must last more than bounce_ms after the recorded press time to be
// debounced; a release after that is a short press, a hold beyond hold_ms is a
// long press followed by a wait for release. Time differences wrap modulo 2^32.
// Throughput is one poll per cycle while the output is not stalled: the state
// update is a 32-bit subtract and two compares between the input register and the result register.
// A poll is held in the input register until its result enters the result
// register. Configuration writes (index 0 bounce_ms, index 1 hold_ms) are for
// the user to make while the block is idle; the block does not enforce this.
module key_press_classifier_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,

    input  logic                      i_cfg_we,
    input  logic [0:0]                i_cfg_index,
    input  logic [kpc_pkg::CFG_W-1:0] i_cfg_data,

    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_key_level,
    input  logic [kpc_pkg::TIME_W-1:0] i_now_ms,

    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [2:0]                o_press_state,
    output logic                      o_short_press,
    output logic                      o_long_press
);

    logic [kpc_pkg::CFG_W-1:0]  r_bounce_ms;
    logic [kpc_pkg::CFG_W-1:0]  r_hold_ms;

    logic                        r_in_valid;
    logic                        r_key_level;
    logic [kpc_pkg::TIME_W-1:0]  r_now_ms;

    kpc_pkg::t_press_state       r_fsm;
    kpc_pkg::t_press_state       n_fsm;
    logic [kpc_pkg::TIME_W-1:0]  r_press_start_ms;
    logic [kpc_pkg::TIME_W-1:0]  n_press_start_ms;

    logic                        r_out_valid;
    logic [2:0]                  r_press_state;
    logic                        r_short_press;
    logic                        r_long_press;

    logic                        out_free;
    logic                        advance;
    logic                        in_accept;
    logic [kpc_pkg::TIME_W-1:0]  elapsed;
    logic                        past_bounce;
    logic                        past_hold;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bounce_ms <= kpc_pkg::BOUNCE_MS_RST;
            r_hold_ms   <= kpc_pkg::HOLD_MS_RST;
        end else if (i_cfg_we) begin
            unique case (kpc_pkg::t_cfg_index'(i_cfg_index))
                kpc_pkg::CFG_BOUNCE_MS: r_bounce_ms <= i_cfg_data;
                kpc_pkg::CFG_HOLD_MS:   r_hold_ms   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake: the result register frees when empty or being taken
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_key_level <= i_key_level;
            r_now_ms    <= i_now_ms;
        end
    end

    assign elapsed     = r_now_ms - r_press_start_ms;
    assign past_bounce = elapsed > {{(kpc_pkg::TIME_W-kpc_pkg::CFG_W){1'b0}}, r_bounce_ms};
    assign past_hold   = elapsed > {{(kpc_pkg::TIME_W-kpc_pkg::CFG_W){1'b0}}, r_hold_ms};

    always_comb begin
        n_fsm            = r_fsm;
        n_press_start_ms = r_press_start_ms;
        unique case (r_fsm)
            kpc_pkg::ST_RESET: begin
                n_fsm = kpc_pkg::ST_WAIT;
            end
            kpc_pkg::ST_WAIT: begin
                if (!r_key_level) n_fsm = kpc_pkg::ST_PRESSED;
            end
            kpc_pkg::ST_PRESSED: begin
                n_press_start_ms = r_now_ms;
                n_fsm            = kpc_pkg::ST_BOUNCE;
            end
            kpc_pkg::ST_BOUNCE: begin
                // release aborts even when the bounce time has passed
                if (r_key_level)      n_fsm = kpc_pkg::ST_RESET;
                else if (past_bounce) n_fsm = kpc_pkg::ST_DEBOUNCE;
            end
            kpc_pkg::ST_DEBOUNCE: begin
                // long hold wins over a release in the same poll
                if (past_hold)        n_fsm = kpc_pkg::ST_LONG;
                else if (r_key_level) n_fsm = kpc_pkg::ST_SHORT;
            end
            kpc_pkg::ST_SHORT: begin
                n_fsm = kpc_pkg::ST_RESET;
            end
            kpc_pkg::ST_LONG: begin
                n_fsm = kpc_pkg::ST_RELEASE;
            end
            kpc_pkg::ST_RELEASE: begin
                if (r_key_level) n_fsm = kpc_pkg::ST_RESET;
            end
            default: begin
                n_fsm = kpc_pkg::ST_RESET;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm            <= kpc_pkg::ST_RESET;
            r_press_start_ms <= '0;
        end else if (advance) begin
            r_fsm            <= n_fsm;
            r_press_start_ms <= n_press_start_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_press_state <= 3'(n_fsm);
            r_short_press <= (n_fsm == kpc_pkg::ST_SHORT);
            r_long_press  <= (n_fsm == kpc_pkg::ST_LONG);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_press_state = r_press_state;
    assign o_short_press = r_short_press;
    assign o_long_press  = r_long_press;

    // Hold state while no poll is processed
    a_fsm_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_fsm))
        else $error("press state changed without a poll");

    a_start_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_fsm == kpc_pkg::ST_PRESSED) |=>
            (r_press_start_ms == $past(r_now_ms)) && (r_fsm == kpc_pkg::ST_BOUNCE))
        else $error("press time not recorded");

    a_long_then_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_fsm == kpc_pkg::ST_LONG) |=> (r_fsm == kpc_pkg::ST_RELEASE))
        else $error("long press not followed by wait for release");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid)
        else $error("input stalled with a free pipeline");

endmodule
